### hdl/wst_pkg.sv
// Shared types, constants and helpers of the waypoint switching tracker.
package wst_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int COORD_BITS_DEF    = 24;

  // Waypoint slots addressable by a load request, and the slot field width.
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = 6;
  localparam int PATH_W     = 7;

  // Entries in the queue between the front and the back.
  localparam int QDEPTH = 2;

  // Configuration port shape.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 16;
  localparam int THR2_W     = 32;

  // Reset values: path of two waypoints (last index one), 50 cm radius squared.
  localparam logic [SLOT_W-1:0] LAST_RESET   = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] TARGET_RESET = SLOT_W'(1);
  localparam logic [THR2_W-1:0] THR2_RESET   = THR2_W'(2500);
  localparam logic [PATH_W-1:0] PATH_MIN     = PATH_W'(2);

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATH_LENGTH     = 1'b0,
    CFG_REACH_THRESHOLD = 1'b1
  } cfg_reg_e;

  // Request kinds as sorted by the front.
  typedef enum logic [1:0] {
    KIND_LOAD      = 2'd0,
    KIND_LOAD_SKIP = 2'd1,
    KIND_SAMPLE    = 2'd2
  } item_kind_e;

  // Control part of one queued request.
  typedef struct packed {
    item_kind_e        kind;
    logic [SLOT_W-1:0] slot;
  } item_ctl_t;

  // Back end sequencer: reload the segment window, then run.
  typedef enum logic [1:0] {
    ST_FILL_LO = 2'd0,
    ST_FILL_HI = 2'd1,
    ST_RUN     = 2'd2
  } back_state_e;

  // Number of table entries that can ever be addressed.
  function automatic int table_depth(int max_wp);
    return (max_wp < SLOT_COUNT) ? max_wp : SLOT_COUNT;
  endfunction

endpackage

### hdl/waypoint_switching_tracker.sv
// Top level of the waypoint switching tracker: configuration registers, front and back.
// The tracker takes one request per clock unless a result is not taken or a window
// update or reload holds it, and answers each with one result. A load that rewrites
// the start, target or next waypoint, and a sample that moves on to the next
// waypoint, hold back the following request while the segment window held in
// registers is updated (one read port of the waypoint table serves that shift).
// After reset, and when path_length is lowered so the target lies past its end,
// the window is reloaded from the table (ST_FILL_LO, ST_FILL_HI) before requests go on.
// The input queue takes two requests, so input is accepted while a result waits.
module waypoint_switching_tracker #(
  parameter int MAX_WAYPOINTS = wst_pkg::MAX_WAYPOINTS_DEF,
  parameter int COORD_BITS    = wst_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wst_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [wst_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [wst_pkg::SLOT_W-1:0]         waypoint_slot_i,
  input  logic signed [COORD_BITS-1:0]       pos_x_i,
  input  logic signed [COORD_BITS-1:0]       pos_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               advanced_o,
  output logic [wst_pkg::SLOT_W-1:0]         target_number_o,
  output logic                               finished_o,
  output logic signed [COORD_BITS-1:0]       goal_x_o,
  output logic signed [COORD_BITS-1:0]       goal_y_o
);

  localparam int DEPTH = wst_pkg::table_depth(MAX_WAYPOINTS);
  localparam int XW    = wst_pkg::PATH_W;
  localparam int IW    = wst_pkg::SLOT_W;

  logic [IW-1:0]                 last_q, last_d;
  logic [wst_pkg::THR2_W-1:0]    thr2_q, thr2_d;
  logic [XW-1:0]                 path_n;
  logic [XW-1:0]                 path_clamped;
  logic [wst_pkg::THR2_W-1:0]    thr_sq;

  logic                          head_valid, head_pop;
  wst_pkg::item_ctl_t            head_ctl;
  logic signed [COORD_BITS-1:0]  head_x, head_y;

  // Path length is kept as its last index, clamped to the usable table.
  assign path_n = cfg_wdata_i[XW-1:0];
  always_comb begin
    if (path_n < wst_pkg::PATH_MIN) begin
      path_clamped = wst_pkg::PATH_MIN;
    end else if (path_n > XW'(DEPTH)) begin
      path_clamped = XW'(DEPTH);
    end else begin
      path_clamped = path_n;
    end
  end

  // Reach radius is kept squared.
  assign thr_sq = cfg_wdata_i[wst_pkg::THR_W-1:0] * cfg_wdata_i[wst_pkg::THR_W-1:0];

  // Register write decode.
  always_comb begin
    last_d = last_q;
    thr2_d = thr2_q;
    if (cfg_we_i) begin
      unique case (wst_pkg::cfg_reg_e'(cfg_addr_i))
        wst_pkg::CFG_PATH_LENGTH:     last_d = IW'(path_clamped - XW'(1));
        wst_pkg::CFG_REACH_THRESHOLD: thr2_d = thr_sq;
        default:                      last_d = last_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= wst_pkg::LAST_RESET;
      thr2_q <= wst_pkg::THR2_RESET;
    end else begin
      last_q <= last_d;
      thr2_q <= thr2_d;
    end
  end

  // Request intake and queue.
  wst_front #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_BITS    (COORD_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .waypoint_slot_i (waypoint_slot_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .head_valid_o    (head_valid),
    .head_ctl_o      (head_ctl),
    .head_x_o        (head_x),
    .head_y_o        (head_y),
    .head_pop_i      (head_pop)
  );

  // Table, segment test and results.
  wst_back #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_ctl_i      (head_ctl),
    .head_x_i        (head_x),
    .head_y_i        (head_y),
    .head_pop_o      (head_pop),
    .last_i          (last_q),
    .thr2_i          (thr2_q),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .advanced_o      (advanced_o),
    .target_number_o (target_number_o),
    .finished_o      (finished_o),
    .goal_x_o        (goal_x_o),
    .goal_y_o        (goal_y_o)
  );

endmodule

### hdl/wst_front.sv
// Front end: sorts incoming requests by kind and queues them for the back end.
module wst_front #(
  parameter int MAX_WAYPOINTS = wst_pkg::MAX_WAYPOINTS_DEF,
  parameter int COORD_BITS    = wst_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [wst_pkg::SLOT_W-1:0]        waypoint_slot_i,
  input  logic signed [COORD_BITS-1:0]      pos_x_i,
  input  logic signed [COORD_BITS-1:0]      pos_y_i,
  output logic                              head_valid_o,
  output wst_pkg::item_ctl_t                head_ctl_o,
  output logic signed [COORD_BITS-1:0]      head_x_o,
  output logic signed [COORD_BITS-1:0]      head_y_o,
  input  logic                              head_pop_i
);

  localparam int DEPTH = wst_pkg::table_depth(MAX_WAYPOINTS);
  localparam int QD    = wst_pkg::QDEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  wst_pkg::item_ctl_t            ctl_in;
  wst_pkg::item_ctl_t            q_ctl_q [QD];
  logic signed [COORD_BITS-1:0]  q_x_q [QD];
  logic signed [COORD_BITS-1:0]  q_y_q [QD];
  logic [PTR_W-1:0]              wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]              rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          push, pop;

  // Sort the request: a load beyond the table writes nothing but still answers.
  always_comb begin
    ctl_in.slot = waypoint_slot_i;
    if (operation_i) begin
      ctl_in.kind = wst_pkg::KIND_SAMPLE;
    end else if ({1'b0, waypoint_slot_i} < wst_pkg::PATH_W'(DEPTH)) begin
      ctl_in.kind = wst_pkg::KIND_LOAD;
    end else begin
      ctl_in.kind = wst_pkg::KIND_LOAD_SKIP;
    end
  end

  assign in_ready_o   = (cnt_q != CNT_W'(QD));
  assign head_valid_o = (cnt_q != '0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = head_pop_i && head_valid_o;

  // Queue pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_ctl_q[wr_ptr_q] <= ctl_in;
      q_x_q[wr_ptr_q]   <= pos_x_i;
      q_y_q[wr_ptr_q]   <= pos_y_i;
    end
  end

  assign head_ctl_o = q_ctl_q[rd_ptr_q];
  assign head_x_o   = q_x_q[rd_ptr_q];
  assign head_y_o   = q_y_q[rd_ptr_q];

endmodule

### hdl/wst_back.sv
// Back end: waypoint table, segment window, reach test and result register.
module wst_back #(
  parameter int MAX_WAYPOINTS = wst_pkg::MAX_WAYPOINTS_DEF,
  parameter int COORD_BITS    = wst_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  wst_pkg::item_ctl_t                head_ctl_i,
  input  logic signed [COORD_BITS-1:0]      head_x_i,
  input  logic signed [COORD_BITS-1:0]      head_y_i,
  output logic                              head_pop_o,
  input  logic [wst_pkg::SLOT_W-1:0]        last_i,
  input  logic [wst_pkg::THR2_W-1:0]        thr2_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              advanced_o,
  output logic [wst_pkg::SLOT_W-1:0]        target_number_o,
  output logic                              finished_o,
  output logic signed [COORD_BITS-1:0]      goal_x_o,
  output logic signed [COORD_BITS-1:0]      goal_y_o
);

  localparam int C     = COORD_BITS;
  localparam int DEPTH = wst_pkg::table_depth(MAX_WAYPOINTS);
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = C + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = (PW + 1 > wst_pkg::THR2_W + 1) ? PW + 1 : wst_pkg::THR2_W + 1;
  localparam int IW    = wst_pkg::SLOT_W;
  localparam int XW    = wst_pkg::PATH_W;

  // Waypoint table, {east, north} per entry.
  logic [2*C-1:0] wp_mem_q [DEPTH];

  // Segment window: start (target-1), end (target) and the next waypoint.
  logic [2*C-1:0] seg_start_q, seg_end_q, seg_next_q;

  wst_pkg::back_state_e state_q, state_d;
  logic                 fill_lo, fill_hi, running;
  logic [IW-1:0]        tgt_q;
  logic                 done_q;

  // Compute stage registers.
  logic                 b_valid_q;
  wst_pkg::item_ctl_t   b_ctl_q;
  logic [2*C-1:0]       b_pos_q;
  logic signed [PW-1:0] b_dot_x_q, b_dot_y_q, b_len_x_q, b_len_y_q, b_dst_x_q, b_dst_y_q;

  // Result register.
  logic                 out_valid_q;
  logic                 out_adv_q, out_fin_q;
  logic [IW-1:0]        out_tgt_q;
  logic signed [C-1:0]  out_gx_q, out_gy_q;

  logic signed [C-1:0]  sx, sy, tx, ty;
  logic signed [DW-1:0] abx, aby, apx, apy, dx, dy;
  logic signed [PW-1:0] dot_x, dot_y, len_x, len_y, dst_x, dst_y;
  logic signed [SW-1:0] len2, dot, dst2, thr2_s;
  logic [XW-1:0]        t_m1, t_p1, t_p2, slot_x;
  logic [AW-1:0]        rd0_addr, rd1_addr;
  logic                 over_end, sat_need, b_fire, b_take;
  logic                 is_sample, is_load, reach, adv, at_last, step, finish;
  logic                 hit_s, hit_t, hit_n, win_chg;
  logic [IW-1:0]        tgt_next;
  logic [2*C-1:0]       goal_next;

  // Sequencer: reload the window after reset or after the target is clamped.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wst_pkg::ST_FILL_LO: state_d = wst_pkg::ST_FILL_HI;
      wst_pkg::ST_FILL_HI: state_d = wst_pkg::ST_RUN;
      wst_pkg::ST_RUN: begin
        if (sat_need) begin
          state_d = wst_pkg::ST_FILL_LO;
        end
      end
      default: state_d = wst_pkg::ST_FILL_LO;
    endcase
  end

  always_comb begin
    fill_lo = 1'b0;
    fill_hi = 1'b0;
    running = 1'b0;
    unique case (state_q)
      wst_pkg::ST_FILL_LO: fill_lo = 1'b1;
      wst_pkg::ST_FILL_HI: fill_hi = 1'b1;
      wst_pkg::ST_RUN:     running = 1'b1;
      default:             fill_lo = 1'b0;
    endcase
  end

  // A shortened path leaves the target past its end; clamp it when a request shows up.
  assign over_end = (tgt_q > last_i);
  assign sat_need = running && head_valid_i && !b_valid_q && over_end;

  // Neighbor indexes of the target.
  assign t_m1   = {1'b0, tgt_q} - XW'(1);
  assign t_p1   = {1'b0, tgt_q} + XW'(1);
  assign t_p2   = {1'b0, tgt_q} + XW'(2);
  assign slot_x = {1'b0, b_ctl_q.slot};

  // Segment geometry against the queued position.
  assign sx = seg_start_q[2*C-1:C];
  assign sy = seg_start_q[C-1:0];
  assign tx = seg_end_q[2*C-1:C];
  assign ty = seg_end_q[C-1:0];

  assign abx = DW'(tx) - DW'(sx);
  assign aby = DW'(ty) - DW'(sy);
  assign apx = DW'(head_x_i) - DW'(sx);
  assign apy = DW'(head_y_i) - DW'(sy);
  assign dx  = DW'(tx) - DW'(head_x_i);
  assign dy  = DW'(ty) - DW'(head_y_i);

  assign dot_x = apx * abx;
  assign dot_y = apy * aby;
  assign len_x = abx * abx;
  assign len_y = aby * aby;
  assign dst_x = dx * dx;
  assign dst_y = dy * dy;

  // Reach test. On a zero-length segment start and end coincide, so the
  // distance to the start equals the distance to the target.
  assign len2   = SW'(b_len_x_q) + SW'(b_len_y_q);
  assign dot    = SW'(b_dot_x_q) + SW'(b_dot_y_q);
  assign dst2   = SW'(b_dst_x_q) + SW'(b_dst_y_q);
  assign thr2_s = SW'(thr2_i);
  assign reach  = ((len2 != '0) && (dot > len2)) || (dst2 < thr2_s);

  assign is_sample = (b_ctl_q.kind == wst_pkg::KIND_SAMPLE);
  assign is_load   = (b_ctl_q.kind == wst_pkg::KIND_LOAD);
  assign adv       = is_sample && !done_q && reach;
  assign at_last   = (tgt_q >= last_i);
  assign step      = adv && !at_last;
  assign finish    = adv && at_last;

  // Loads that land inside the window are written through to it.
  assign hit_s = is_load && (slot_x == t_m1);
  assign hit_t = is_load && (slot_x == {1'b0, tgt_q});
  assign hit_n = is_load && (slot_x == t_p1);

  assign tgt_next = step ? tgt_q + IW'(1) : tgt_q;
  always_comb begin
    if (step) begin
      goal_next = seg_next_q;
    end else if (hit_t) begin
      goal_next = b_pos_q;
    end else begin
      goal_next = seg_end_q;
    end
  end

  // Handshakes between queue, compute stage and result register. A request
  // whose geometry was taken from a window that changes this cycle waits.
  assign b_fire     = b_valid_q && (!out_valid_q || out_ready_i);
  assign win_chg    = b_fire && (step || hit_s || hit_t || hit_n);
  assign b_take     = running && head_valid_i && !over_end && (!b_valid_q || b_fire)
                      && !win_chg;
  assign head_pop_o = b_take;

  // Read port addresses: port 0 serves start and next, port 1 the end point.
  always_comb begin
    if (fill_lo) begin
      rd0_addr = t_m1[AW-1:0];
    end else if (fill_hi) begin
      rd0_addr = t_p1[AW-1:0];
    end else begin
      rd0_addr = t_p2[AW-1:0];
    end
  end
  assign rd1_addr = tgt_q[AW-1:0];

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (b_fire && is_load) begin
      wp_mem_q[b_ctl_q.slot[AW-1:0]] <= b_pos_q;
    end
  end

  // Window update: reload, shift on advance, or write-through on load.
  always_ff @(posedge clk_i) begin
    if (fill_lo) begin
      seg_start_q <= wp_mem_q[rd0_addr];
      seg_end_q   <= wp_mem_q[rd1_addr];
    end else if (fill_hi) begin
      seg_next_q <= wp_mem_q[rd0_addr];
    end else if (b_fire) begin
      if (step) begin
        seg_start_q <= seg_end_q;
        seg_end_q   <= seg_next_q;
        seg_next_q  <= wp_mem_q[rd0_addr];
      end else begin
        if (hit_s) begin
          seg_start_q <= b_pos_q;
        end
        if (hit_t) begin
          seg_end_q <= b_pos_q;
        end
        if (hit_n) begin
          seg_next_q <= b_pos_q;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wst_pkg::ST_FILL_LO;
      tgt_q       <= wst_pkg::TARGET_RESET;
      done_q      <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sat_need) begin
        tgt_q <= last_i;
      end else if (b_fire) begin
        tgt_q <= tgt_next;
      end
      if (b_fire && finish) begin
        done_q <= 1'b1;
      end
      if (b_take) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Compute stage payload: products registered ahead of the sums and compares.
  always_ff @(posedge clk_i) begin
    if (b_take) begin
      b_ctl_q   <= head_ctl_i;
      b_pos_q   <= {head_x_i, head_y_i};
      b_dot_x_q <= dot_x;
      b_dot_y_q <= dot_y;
      b_len_x_q <= len_x;
      b_len_y_q <= len_y;
      b_dst_x_q <= dst_x;
      b_dst_y_q <= dst_y;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_adv_q <= adv;
      out_tgt_q <= tgt_next;
      out_fin_q <= done_q || finish;
      out_gx_q  <= goal_next[2*C-1:C];
      out_gy_q  <= goal_next[C-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign advanced_o      = out_adv_q;
  assign target_number_o = out_tgt_q;
  assign finished_o      = out_fin_q;
  assign goal_x_o        = out_gx_q;
  assign goal_y_o        = out_gy_q;

endmodule
